// ===== hw/rtl/itp_pkg.sv =====
// Shared types and codes for the infix to postfix converter.
// Stack entry, result record, token and status codes, control states.
// No dependencies.
package itp_pkg;

    localparam int VALUE_W = 32;
    localparam int PREC_W  = 4;
    localparam int CMD_W   = 3;

    // Token kinds on the input channel
    typedef enum logic [CMD_W-1:0] {
        CMD_OPERAND  = 3'd0,
        CMD_OPERATOR = 3'd1,
        CMD_OPEN     = 3'd2,
        CMD_CLOSE    = 3'd3,
        CMD_END      = 3'd4
    } t_cmd;

    // Result kinds on the output channel
    typedef enum logic [1:0] {
        KIND_OPERAND  = 2'd0,
        KIND_OPERATOR = 2'd1,
        KIND_STATUS   = 2'd2
    } t_kind;

    // Status codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_PAREN    = 2'd1,
        ERR_SYNTAX   = 2'd2,
        ERR_OVERFLOW = 2'd3
    } t_err;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_FLUSH
    } t_state;

    // One stack entry: operator code, precedence, open-paren marker
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PREC_W-1:0]  prec;
        logic               paren;
    } t_entry;

    // One result as handed to the output stage
    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        t_err               err;
        logic               last;
    } t_result;

endpackage

// ===== hw/rtl/infix_to_postfix_converter.sv =====
// Top level of the infix to postfix converter (shunting-yard).
// Instantiates itp_ctrl, itp_stack_mem and itp_out_stage; uses itp_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall / i_command, i_token_value, i_precedence)
//   takes one infix token per transfer. Output channel (o_valid / i_stall /
//   o_out_kind, o_out_value, o_error_code, o_last) gives the postfix stream;
//   o_last marks the final result caused by a token, and an end mark always
//   closes with a status result unless an error was already reported.
//   Flow: one token is handled at a time. An open paren is pushed directly in
//   the idle state unless the stack is full; an operand passes through the result
//   hold into the output register. An operator, close paren or end mark first
//   fetches the top of stack, then pops operators, reading the stack memory
//   once a cycle while the result hold can move on, and finally releases its
//   last result from the hold. The stack read data is registered, so the top
//   entry is fetched before the first pop decision.
//   Stall: the output register holds a result while i_stall is high, and the
//   block keeps working until it has a further result to hand over; o_stall
//   is high whenever a token is in progress.
//   Reset: synchronous, active low; empties the stack and clears the error
//   latch. Stack contents need no clearing; only entries below the count are read.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_token_value,
    input  logic [3:0]  i_precedence,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_kind,
    output logic [31:0] o_out_value,
    output logic [1:0]  o_error_code,
    output logic        o_last
);
    import itp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_entry        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          out_free;
    logic          out_load;
    t_result       out_res;

    itp_ctrl #(
        .DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_token_value (i_token_value),
        .i_precedence  (i_precedence),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .i_out_free    (out_free),
        .o_out_load    (out_load),
        .o_out_res     (out_res)
    );

    itp_stack_mem #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    itp_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (out_load),
        .i_res        (out_res),
        .o_free       (out_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_kind   (o_out_kind),
        .o_out_value  (o_out_value),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

endmodule

// ===== hw/rtl/itp_stack_mem.sv =====
// Operator stack storage: one write port, one read port, registered read data.
// Depends on itp_pkg for the entry type.
module itp_stack_mem #(
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output itp_pkg::t_entry          o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  itp_pkg::t_entry          i_wr_data
);
    import itp_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/itp_out_stage.sv =====
// Output register of the converter: holds one result until its transfer.
// Depends on itp_pkg for the result record.
module itp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  itp_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_out_kind,
    output logic [31:0]      o_out_value,
    output logic [1:0]       o_error_code,
    output logic             o_last
);
    import itp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or when the held result transfers this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_kind   = r_res.kind;
    assign o_out_value  = r_res.value;
    assign o_error_code = r_res.err;
    assign o_last       = r_res.last;

endmodule

// ===== hw/rtl/itp_ctrl.sv =====
// Shunting-yard controller: token decode, pop loop over the stack memory,
// stack count, error latch and a one-deep result hold that settles the last flag.
// Depends on itp_pkg.
module itp_ctrl #(
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // token channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_command,
    input  logic [31:0]              i_token_value,
    input  logic [3:0]               i_precedence,
    // stack memory
    output logic                     o_rd_en,
    output logic [$clog2(DEPTH)-1:0] o_rd_addr,
    input  itp_pkg::t_entry          i_rd_data,
    output logic                     o_wr_en,
    output logic [$clog2(DEPTH)-1:0] o_wr_addr,
    output itp_pkg::t_entry          o_wr_data,
    // output stage
    input  logic                     i_out_free,
    output logic                     o_out_load,
    output itp_pkg::t_result         o_out_res
);
    import itp_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_err, n_err;
    t_cmd                r_cmd, n_cmd;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [PREC_W-1:0]   r_prec, n_prec;
    logic                r_hold_v, n_hold_v;
    t_result             r_hold, n_hold;

    t_cmd                in_cmd;
    logic                pop_ok;
    logic                can_emit;

    assign in_cmd = t_cmd'(i_command);

    // top entry pops: an operator, and for an operator token one of equal or higher rank
    assign pop_ok = (r_count != '0) && !i_rd_data.paren
                    && ((r_cmd != CMD_OPERATOR) || (i_rd_data.prec >= r_prec));

    // a new result may enter the hold if the hold is empty or can move on
    assign can_emit = !r_hold_v || i_out_free;

    assign o_stall = (r_state != S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_err    <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_err    <= n_err;
            r_hold_v <= n_hold_v;
        end
    end

    // token and held result payload
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_val  <= n_val;
        r_prec <= n_prec;
        r_hold <= n_hold;
    end

    // next state, memory requests and result moves
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_err      = r_err;
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_prec     = r_prec;
        n_hold_v   = r_hold_v;
        n_hold     = r_hold;
        o_rd_en    = 1'b0;
        o_rd_addr  = AW'(r_count - CW'(1));
        o_wr_en    = 1'b0;
        o_wr_addr  = r_count[AW-1:0];
        o_wr_data  = '{value: r_val, prec: r_prec, paren: 1'b0};
        o_out_load = 1'b0;
        o_out_res  = r_hold;
        o_out_res.last = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd  = in_cmd;
                    n_val  = i_token_value;
                    n_prec = i_precedence;
                    if (r_err) begin
                        // after an error only the end mark counts: it resets silently
                        if (in_cmd == CMD_END) begin
                            n_count = '0;
                            n_err   = 1'b0;
                        end
                    end else begin
                        unique case (in_cmd)
                            CMD_OPERAND: begin
                                n_hold   = '{kind: KIND_OPERAND, value: i_token_value,
                                             err: ERR_NONE, last: 1'b0};
                                n_hold_v = 1'b1;
                                n_state  = S_FLUSH;
                            end
                            CMD_OPERATOR, CMD_CLOSE, CMD_END: begin
                                // fetch top of stack for the pop loop
                                o_rd_en = (r_count != '0);
                                n_state = S_POP;
                            end
                            CMD_OPEN: begin
                                if (r_count == FULL) begin
                                    n_hold   = '{kind: KIND_STATUS, value: '0,
                                                 err: ERR_OVERFLOW, last: 1'b0};
                                    n_hold_v = 1'b1;
                                    n_err    = 1'b1;
                                    n_state  = S_FLUSH;
                                end else begin
                                    o_wr_en   = 1'b1;
                                    o_wr_data = '{value: i_token_value, prec: '0,
                                                  paren: 1'b1};
                                    n_count   = r_count + CW'(1);
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            S_POP: begin
                if (pop_ok) begin
                    // emit the top operator and fetch the entry below it
                    if (can_emit) begin
                        o_out_load = r_hold_v;
                        n_hold     = '{kind: KIND_OPERATOR, value: i_rd_data.value,
                                       err: ERR_NONE, last: 1'b0};
                        n_hold_v   = 1'b1;
                        n_count    = r_count - CW'(1);
                        o_rd_en    = (r_count > CW'(1));
                        o_rd_addr  = AW'(r_count - CW'(2));
                    end
                end else begin
                    unique case (r_cmd)
                        CMD_OPERATOR: begin
                            if (r_count == FULL) begin
                                // full only when nothing popped, so the hold is empty
                                n_hold   = '{kind: KIND_STATUS, value: '0,
                                             err: ERR_OVERFLOW, last: 1'b0};
                                n_hold_v = 1'b1;
                                n_err    = 1'b1;
                                n_state  = S_FLUSH;
                            end else begin
                                o_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                                n_state = r_hold_v ? S_FLUSH : S_IDLE;
                            end
                        end
                        CMD_CLOSE: begin
                            if (r_count == '0) begin
                                // no matching open paren
                                if (can_emit) begin
                                    o_out_load = r_hold_v;
                                    n_hold     = '{kind: KIND_STATUS, value: '0,
                                                   err: ERR_PAREN, last: 1'b0};
                                    n_hold_v   = 1'b1;
                                    n_err      = 1'b1;
                                    n_state    = S_FLUSH;
                                end
                            end else begin
                                // drop the open paren
                                n_count = r_count - CW'(1);
                                n_state = r_hold_v ? S_FLUSH : S_IDLE;
                            end
                        end
                        CMD_END: begin
                            if (can_emit) begin
                                o_out_load = r_hold_v;
                                n_hold     = '{kind: KIND_STATUS, value: '0,
                                               err: (r_count != '0) ? ERR_SYNTAX : ERR_NONE,
                                               last: 1'b0};
                                n_hold_v   = 1'b1;
                                n_count    = '0;
                                n_err      = 1'b0;
                                n_state    = S_FLUSH;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_FLUSH: begin
                // the held result is the final one of this token
                if (i_out_free) begin
                    o_out_load     = 1'b1;
                    o_out_res.last = 1'b1;
                    n_hold_v       = 1'b0;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/itp_checker.sv =====
// Port-level checks for the infix to postfix converter, bound to the top level.
// Depends on itp_pkg for result and status codes.
module itp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [1:0]  o_out_kind,
    input  logic [31:0] o_out_value,
    input  logic [1:0]  o_error_code,
    input  logic        o_last
);
    import itp_pkg::*;

    // a stalled result stays put until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_value) && $stable(o_out_kind)
                               && $stable(o_error_code) && $stable(o_last))
        else $error("result changed while stalled");

    // a status result always ends the token's results
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == KIND_STATUS) |-> o_last)
        else $error("status result without last");

    // operands and operators carry no error code
    a_data_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind != KIND_STATUS) |-> (o_error_code == ERR_NONE))
        else $error("error code on a data result");

    // status results carry a zero value
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == KIND_STATUS) |-> (o_out_value == '0))
        else $error("nonzero value on a status result");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_kind   (o_out_kind),
    .o_out_value  (o_out_value),
    .o_error_code (o_error_code),
    .o_last       (o_last)
);

// ===== test/tb_top.sv =====
// Testbench for infix_to_postfix_converter: drives infix tokens over the valid/stall
// input channel and checks the postfix stream against an in-bench shunting-yard model.
// Depends on itp_pkg and the converter RTL only.
`timescale 1ns / 100ps

module tb_top;
    import itp_pkg::*;

    localparam int DEPTH        = 32;
    localparam int RANDOM_ITEMS = 305;
    localparam int TAIL_CYCLES  = 64;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;

    // Command codes the block does not define
    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] val;
        logic [3:0]  prec;
    } t_tok;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] val;
        logic [3:0]  prec;
        bit          typed;
        t_kind       kind;
        logic [31:0] value;
        t_err        err;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [2:0]  i_command     = '0;
    logic [31:0] i_token_value = '0;
    logic [3:0]  i_precedence  = '0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_out_kind;
    logic [31:0] o_out_value;
    logic [1:0]  o_error_code;
    logic        o_last;

    infix_to_postfix_converter #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_token_value (i_token_value),
        .i_precedence  (i_precedence),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_kind    (o_out_kind),
        .o_out_value   (o_out_value),
        .o_error_code  (o_error_code),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Shunting-yard state mirrored in the bench
    t_entry  op_stack [DEPTH];
    int      op_depth    = 0;
    bit      err_latched = 1'b0;
    t_result step_out [$];
    t_result postfix_due [$];
    t_tok    tok_q [$];

    int mismatch_count   = 0;
    int cycle_count      = 0;
    int tx_calm          = 0;
    int rx_calm          = 0;
    int long_hold_cycles = 0;
    bit drain_next       = 1'b0;

    function automatic void emit_result(t_kind k, logic [31:0] v, t_err e);
        step_out.push_back('{kind: k, value: v, err: e, last: 1'b0});
    endfunction

    // Pop operators down to an open paren; with by_prec, only those binding as tight
    function automatic void pop_operators(bit by_prec, logic [3:0] prec);
        while (op_depth > 0) begin
            if (op_stack[op_depth-1].paren || (by_prec && op_stack[op_depth-1].prec < prec))
                break;
            emit_result(KIND_OPERATOR, op_stack[op_depth-1].value, ERR_NONE);
            op_depth--;
        end
    endfunction

    function automatic void stack_push(logic [31:0] v, logic [3:0] p, logic par);
        if (op_depth >= DEPTH) begin
            emit_result(KIND_STATUS, '0, ERR_OVERFLOW);
            err_latched = 1'b1;
        end else begin
            op_stack[op_depth] = '{value: v, prec: p, paren: par};
            op_depth++;
        end
    endfunction

    // Results caused by one accepted token, left in step_out
    function automatic void shunt_token(logic [2:0] cmd, logic [31:0] val, logic [3:0] prec);
        step_out.delete();
        if (err_latched) begin
            if (cmd == CMD_END) begin
                op_depth    = 0;
                err_latched = 1'b0;
            end
            return;
        end
        case (cmd)
            CMD_OPERAND: emit_result(KIND_OPERAND, val, ERR_NONE);
            CMD_OPERATOR: begin
                pop_operators(1'b1, prec);
                stack_push(val, prec, 1'b0);
            end
            CMD_OPEN: stack_push(val, '0, 1'b1);
            CMD_CLOSE: begin
                pop_operators(1'b0, '0);
                if (op_depth == 0) begin
                    emit_result(KIND_STATUS, '0, ERR_PAREN);
                    err_latched = 1'b1;
                end else begin
                    op_depth--;
                end
            end
            CMD_END: begin
                pop_operators(1'b0, '0);
                if (op_depth != 0)
                    emit_result(KIND_STATUS, '0, ERR_SYNTAX);
                else
                    emit_result(KIND_STATUS, '0, ERR_NONE);
                op_depth = 0;
            end
            default: ;
        endcase
        if (step_out.size() > 0)
            step_out[step_out.size()-1].last = 1'b1;
    endfunction

    // Idle cycles before the next transfer; now and then a run with no idling
    function automatic int pick_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Random token content
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] rand_prec();
        if ($urandom_range(0, 1) == 0)
            return 4'($urandom_range(0, 3));
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic void add_tok(logic [2:0] c);
        tok_q.push_back('{cmd: c, val: rand_word(), prec: rand_prec()});
    endfunction

    function automatic void add_term(int nest);
        if (nest > 0 && $urandom_range(0, 3) == 0) begin
            add_tok(CMD_OPEN);
            add_expr(nest - 1);
            add_tok(CMD_CLOSE);
        end else begin
            add_tok(CMD_OPERAND);
        end
    endfunction

    function automatic void add_expr(int nest);
        int n_ops = $urandom_range(0, 4);
        add_term(nest);
        for (int k = 0; k < n_ops; k++) begin
            add_tok(CMD_OPERATOR);
            add_term(nest);
        end
    endfunction

    // Nesting deep enough to fill the stack, mostly closed again
    function automatic void add_deep();
        int levels = $urandom_range(20, 34);
        for (int k = 0; k < levels; k++) begin
            add_tok(CMD_OPEN);
            if ($urandom_range(0, 1) == 1) begin
                add_tok(CMD_OPERAND);
                add_tok(CMD_OPERATOR);
            end
        end
        add_tok(CMD_OPERAND);
        for (int k = 0; k < levels; k++)
            if ($urandom_range(0, 7) != 0)
                add_tok(CMD_CLOSE);
        add_tok(CMD_END);
    endfunction

    // Arbitrary tokens, spare codes included
    function automatic void add_noise();
        int n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
            add_tok(3'($urandom_range(0, 7)));
        if ($urandom_range(0, 1) == 1)
            add_tok(CMD_END);
    endfunction

    // One input transfer, then its expected results go on the due list
    task automatic offer_token(logic [2:0] cmd, logic [31:0] val, logic [3:0] prec,
                               bit typed, t_result pinned);
        int gap = pick_wait(tx_calm);
        if (drain_next) begin
            drain_next = 1'b0;
            i_valid <= 1'b0;
            do @(posedge i_clk); while (postfix_due.size() != 0);
        end else if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_token_value <= val;
        i_precedence  <= prec;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        shunt_token(cmd, val, prec);
        if (typed)
            postfix_due.push_back(pinned);
        else
            foreach (step_out[k])
                postfix_due.push_back(step_out[k]);
    endtask

    // Directed tokens; typed rows carry their one result
    t_dir_row directed_rows [25] = '{
        '{CMD_END,       32'h0,        4'd0,  1'b1, KIND_STATUS,  32'h0,        ERR_NONE},
        '{CMD_OPERAND,   32'h0,        4'd0,  1'b1, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_OPERAND,   32'hFFFFFFFF, 4'd15, 1'b1, KIND_OPERAND, 32'hFFFFFFFF, ERR_NONE},
        '{CMD_END,       32'hFFFFFFFF, 4'd15, 1'b1, KIND_STATUS,  32'h0,        ERR_NONE},
        '{CMD_CLOSE,     32'h29,       4'd0,  1'b1, KIND_STATUS,  32'h0,        ERR_PAREN},
        '{CMD_OPERAND,   32'h12345678, 4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_OPERATOR,  32'h2B,       4'd3,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_END,       32'h0,        4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_OPEN,      32'hAAAA5555, 4'd9,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_END,       32'h0,        4'd0,  1'b1, KIND_STATUS,  32'h0,        ERR_SYNTAX},
        '{CMD_OPERAND,   32'h1,        4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_OPERATOR,  32'h2B,       4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_OPERAND,   32'h2,        4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_OPERATOR,  32'hFFFFFFFF, 4'd15, 1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_OPERAND,   32'h3,        4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_OPERATOR,  32'h2D,       4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_OPEN,      32'h0,        4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_OPERAND,   32'h4,        4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_OPERATOR,  32'h2A,       4'd15, 1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_OPERAND,   32'h5,        4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_CLOSE,     32'h0,        4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_SPARE_LO,  32'hDEADBEEF, 4'd7,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_SPARE_HI,  32'h0,        4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_END,       32'h0,        4'd0,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE},
        '{CMD_SPARE_MID, 32'h5A5A5A5A, 4'd5,  1'b0, KIND_OPERAND, 32'h0,        ERR_NONE}
    };

    // Token source: directed table, then random expressions, deep nesting and noise tokens
    initial begin : token_source
        int   live_count;
        int   roll;
        bit   hold_done;
        bit   drain_done;
        t_tok tk;
        live_count = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        wait (i_rst_n == 1'b1);
        @(posedge i_clk);
        foreach (directed_rows[r])
            offer_token(directed_rows[r].cmd, directed_rows[r].val, directed_rows[r].prec,
                        directed_rows[r].typed,
                        '{kind: directed_rows[r].kind, value: directed_rows[r].value,
                          err: directed_rows[r].err, last: 1'b1});
        while (live_count < RANDOM_ITEMS) begin
            tok_q.delete();
            roll = $urandom_range(0, 19);
            if (roll < 15) begin
                add_expr($urandom_range(0, 3));
                add_tok(CMD_END);
            end else if (roll < 16) begin
                add_deep();
            end else begin
                add_noise();
            end
            while (tok_q.size() > 0) begin
                tk = tok_q.pop_front();
                live_count++;
                // back-pressure: long receiver hold, later a full drain
                if (!hold_done && live_count >= 80) begin
                    hold_done        = 1'b1;
                    long_hold_cycles = HOLD_CYCLES;
                end
                if (!drain_done && live_count >= 220) begin
                    drain_done = 1'b1;
                    drain_next = 1'b1;
                end
                offer_token(tk.cmd, tk.val, tk.prec, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;
        while (postfix_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result sink: random stall before each transfer, one long hold on request
    initial begin : result_sink
        int n;
        wait (i_rst_n == 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold_cycles > 0) begin
                n = long_hold_cycles;
                long_hold_cycles = 0;
            end else begin
                n = pick_wait(rx_calm);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_stall == 1'b0));
        end
    end

    task automatic note_mismatch(bit has_want, t_result want);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (has_want)
                $display("mismatch: want kind %0d value %h err %0d last %0d",
                         want.kind, want.value, want.err, want.last,
                         ", got kind %0d value %h err %0d last %0d",
                         o_out_kind, o_out_value, o_error_code, o_last);
            else
                $display("mismatch: no result due, got kind %0d value %h err %0d last %0d",
                         o_out_kind, o_out_value, o_error_code, o_last);
        end
    endtask

    // Compare each output transfer with the oldest due result
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (postfix_due.size() == 0) begin
                note_mismatch(1'b0, '0);
            end else begin
                want = postfix_due.pop_front();
                if (o_out_kind !== want.kind || o_out_value !== want.value ||
                    o_error_code !== want.err || o_last !== want.last)
                    note_mismatch(1'b1, want);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

// ===== files.f =====
hw/rtl/itp_pkg.sv
hw/rtl/itp_stack_mem.sv
hw/rtl/itp_out_stage.sv
hw/rtl/itp_ctrl.sv
hw/rtl/infix_to_postfix_converter.sv
hw/rtl/itp_checker.sv
test/tb_top.sv
